@@ hdl/least_squares_gradient_reflect_defines.svh @@
// Assertion macros shared by the gradient store RTL.
`ifndef LEAST_SQUARES_GRADIENT_REFLECT_DEFINES_SVH
`define LEAST_SQUARES_GRADIENT_REFLECT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define LSGR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define LSGR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/lsgr_pkg.sv @@
// Package with shared constants, codes, types and saturation helper.
`default_nettype none
package lsgr_pkg;
    localparam int MAX_CELLS_DEF = 1024;
    localparam int NUM_DIMS      = 3;
    localparam int NUM_VARS      = 5;
    localparam int DW            = 32;
    localparam int AW            = 31;
    localparam int IDXW          = 10;
    localparam int VARW          = 3;
    localparam int SATW          = 53;

    localparam logic [1:0] REQ_BEGIN    = 2'd0;
    localparam logic [1:0] REQ_NEIGHBOR = 2'd1;
    localparam logic [1:0] REQ_REFLECT  = 2'd2;
    localparam logic [1:0] REQ_READ     = 2'd3;

    localparam logic [1:0] PH_NB  = 2'd0;
    localparam logic [1:0] PH_DOT = 2'd1;
    localparam logic [1:0] PH_REF = 2'd2;

    typedef logic signed [DW-1:0] word_t;

    typedef struct packed {
        logic       rd_en;
        logic       wr_en;
        logic       wr_zero;
        logic       load_centre;
        logic       load_grad;
        logic       mul_en;
        logic       acc_en;
        logic       clear_acc;
        logic [1:0] phase;
        logic [1:0] dim;
    } lane_ctrl_t;

    // Clamp a wide signed value to the 32-bit signed range.
    function automatic word_t sat32(input logic signed [SATW-1:0] x);
        word_t r;
        if (x[SATW-1:DW-1] == '0 || x[SATW-1:DW-1] == '1)
        begin
            r = x[DW-1:0];
        end
        else if (x[SATW-1])
        begin
            r = {1'b1, {(DW-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(DW-1){1'b1}}};
        end
        return r;
    endfunction
endpackage
`default_nettype wire

@@ hdl/lsgr_if.sv @@
// Handshake interfaces for the request and result channels.
`default_nettype none
interface lsgr_in_if import lsgr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [IDXW-1:0]   cell_index;
    logic [IDXW-1:0]   source_index;
    logic signed [DW-1:0] coef_x;
    logic signed [DW-1:0] coef_y;
    logic signed [DW-1:0] coef_z;
    logic [AW-1:0]     face_size;
    logic signed [DW-1:0] val_density;
    logic signed [DW-1:0] val_vel_x;
    logic signed [DW-1:0] val_vel_y;
    logic signed [DW-1:0] val_vel_z;
    logic signed [DW-1:0] val_pressure;

    modport source (output valid, req_type, cell_index, source_index, coef_x, coef_y,
                    coef_z, face_size, val_density, val_vel_x, val_vel_y, val_vel_z,
                    val_pressure, input ready);
    modport sink (input valid, req_type, cell_index, source_index, coef_x, coef_y,
                  coef_z, face_size, val_density, val_vel_x, val_vel_y, val_vel_z,
                  val_pressure, output ready);
endinterface

interface lsgr_out_if import lsgr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [VARW-1:0]   var_index;
    logic signed [DW-1:0] grad_x;
    logic signed [DW-1:0] grad_y;
    logic signed [DW-1:0] grad_z;
    logic              last_result;

    modport source (output valid, var_index, grad_x, grad_y, grad_z, last_result,
                    input ready);
    modport sink (input valid, var_index, grad_x, grad_y, grad_z, last_result,
                  output ready);
endinterface
`default_nettype wire

@@ hdl/lsgr_div.sv @@
// Restoring divider that normalizes one face normal component by the area.
`default_nettype none
module lsgr_div import lsgr_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  word_t         num,
    input  logic [AW-1:0] den,
    output word_t         quo,
    output logic          done
);
    localparam int NW   = DW + 16;
    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   num_reg;
    logic [AW-1:0]   rem_reg;
    logic [AW-1:0]   den_reg;
    logic            neg_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [DW-1:0]   mag;
    logic [AW:0]     trial;
    logic [AW:0]     diff;
    logic            ge;
    logic signed [SATW-1:0] qs;

    assign mag   = num[DW-1] ? (~num + 1'b1) : num;
    assign trial = {rem_reg, num_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(NW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {mag, 16'b0};
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[DW-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[AW-1:0] : trial[AW-1:0];
            num_reg <= {num_reg[NW-2:0], ge};
        end
    end

    // The quotient register holds the magnitude; the sign is applied on the way out.
    assign qs   = neg_reg ? -$signed(SATW'(num_reg)) : $signed(SATW'(num_reg));
    assign quo  = sat32(qs);
    assign done = done_reg;
endmodule
`default_nettype wire

@@ hdl/lsgr_lane.sv @@
// One variable lane: gradient memory for one flow variable and its arithmetic.
`default_nettype none
module lsgr_lane import lsgr_pkg::*; #(
    parameter int MAX_CELLS = MAX_CELLS_DEF,
    localparam int CW = $clog2(MAX_CELLS)
) (
    input  logic       clk,
    input  logic       rst_n,
    input  lane_ctrl_t ctrl,
    input  logic [CW-1:0] rd_addr,
    input  logic [CW-1:0] wr_addr,
    input  word_t      val,
    input  word_t      coef [NUM_DIMS],
    input  word_t      nrm [NUM_DIMS],
    output word_t      grad [NUM_DIMS]
);
    logic [NUM_DIMS*DW-1:0] mem [MAX_CELLS];
    logic [NUM_DIMS*DW-1:0] rdata_reg;
    word_t                  centre_reg;
    word_t                  g_reg [NUM_DIMS];
    logic signed [64:0]     prod_reg;
    logic signed [50:0]     acc_reg;

    logic signed [32:0]     mul_a;
    word_t                  mul_b;
    word_t                  dot;
    logic signed [48:0]     shifted;

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= ctrl.wr_zero ? '0 : {g_reg[2], g_reg[1], g_reg[0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_reg <= '0;
        end
        else if (ctrl.load_centre)
        begin
            centre_reg <= val;
        end
    end

    assign dot     = sat32(SATW'(acc_reg));
    assign shifted = prod_reg[64:16];

    always_comb
    begin
        case (ctrl.phase)
            PH_DOT:
            begin
                mul_a = 33'(g_reg[ctrl.dim]);
                mul_b = nrm[ctrl.dim];
            end
            PH_REF:
            begin
                mul_a = 33'(dot);
                mul_b = nrm[ctrl.dim];
            end
            default:
            begin
                mul_a = 33'(val) - 33'(centre_reg);
                mul_b = coef[ctrl.dim];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (ctrl.clear_acc)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en && ctrl.phase == PH_DOT)
        begin
            acc_reg <= acc_reg + 51'(shifted);
        end
        if (ctrl.load_grad)
        begin
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                g_reg[d] <= rdata_reg[d*DW +: DW];
            end
        end
        else if (ctrl.acc_en)
        begin
            case (ctrl.phase)
                PH_NB:
                begin
                    g_reg[ctrl.dim] <= sat32(SATW'(g_reg[ctrl.dim]) + SATW'(shifted));
                end
                PH_REF:
                begin
                    g_reg[ctrl.dim] <= sat32(SATW'(g_reg[ctrl.dim]) - (SATW'(shifted) <<< 1));
                end
                default:
                begin
                end
            endcase
        end
    end

    assign grad = g_reg;
endmodule
`default_nettype wire

@@ hdl/lsgr_merge.sv @@
// Merging stage that sends the five lane gradients out one beat each.
`default_nettype none
module lsgr_merge import lsgr_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  word_t grads [NUM_VARS][NUM_DIMS],
    lsgr_out_if.source result,
    output logic done
);
    logic [VARW-1:0] cnt_reg;
    logic            valid_reg;
    logic            last;

    assign last = cnt_reg == VARW'(NUM_VARS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (start)
        begin
            valid_reg <= 1'b1;
            cnt_reg   <= '0;
        end
        else if (valid_reg && result.ready)
        begin
            if (last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign result.valid       = valid_reg;
    assign result.var_index   = cnt_reg;
    assign result.grad_x      = grads[cnt_reg][0];
    assign result.grad_y      = grads[cnt_reg][1];
    assign result.grad_z      = grads[cnt_reg][2];
    assign result.last_result = last;
    assign done               = valid_reg && result.ready && last;
endmodule
`default_nettype wire

@@ hdl/least_squares_gradient_reflect.sv @@
// Top level of the least-squares gradient store with boundary reflection.
//
//  Channel  Dir  Beat contents
//  item     in   request code, cell and source index, three coefficients,
//                face area, five centre or neighbor values
//  result   out  variable index, three gradient components, last flag
//
// One request is worked at a time; item.ready is high only while idle.
// Begin zeroes the gradients and loads the centre values; neighbor accumulates and
// writes back; read sends five result beats. Reflect with a nonzero area sends five
// beats; bit-serial dividers (48 steps) and each lane's shared multiplier pace it.
// Reset clears control and the centre values; the gradient memories are not cleared.
// A stall on result holds the block until the fifth beat is taken.
`default_nettype none
`include "least_squares_gradient_reflect_defines.svh"
module least_squares_gradient_reflect import lsgr_pkg::*; #(
    parameter int MAX_CELLS = MAX_CELLS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    lsgr_in_if.sink item,
    lsgr_out_if.source result
);
    localparam int CW = $clog2(MAX_CELLS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BEGIN = 4'd1;
    localparam logic [3:0] S_READ  = 4'd2;
    localparam logic [3:0] S_LOAD  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_ACC   = 4'd6;
    localparam logic [3:0] S_WRITE = 4'd7;
    localparam logic [3:0] S_SHOW  = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    // Cell indexes beyond the store wrap around; a short compare-subtract chain
    // reduces the narrow index field.
    function automatic logic [CW-1:0] cell_of(input logic [IDXW-1:0] idx);
        logic [IDXW-1:0] r;
        r = idx;
        if (MAX_CELLS < (1 << IDXW))
        begin
            for (int k = IDXW - 1; k >= 0; k--)
            begin
                if (int'(r) >= (MAX_CELLS << k))
                begin
                    r = IDXW'(int'(r) - (MAX_CELLS << k));
                end
            end
        end
        return CW'(r);
    endfunction

    logic [3:0]    state_reg, state_next;
    logic [1:0]    phase_reg, phase_next;
    logic [1:0]    dim_reg, dim_next;
    logic [1:0]    req_reg;
    logic [CW-1:0] cell_reg;
    logic [CW-1:0] src_reg;
    word_t         coef_reg [NUM_DIMS];
    logic [AW-1:0] area_reg;
    word_t         val_reg [NUM_VARS];

    lane_ctrl_t    ctrl;
    logic          accept;
    logic          div_start;
    logic          emit_start;
    logic          emit_done;
    logic          area_zero;
    logic [NUM_DIMS-1:0] div_done;
    word_t         nrm [NUM_DIMS];
    word_t         grads [NUM_VARS][NUM_DIMS];
    logic [CW-1:0] rd_addr;

    assign item.ready = state_reg == S_IDLE;
    assign accept     = item.valid && item.ready;
    assign area_zero  = area_reg == '0;
    assign rd_addr    = (req_reg == REQ_REFLECT) ? src_reg : cell_reg;

    // The request beat is captured once; lanes and dividers work from these copies.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg     <= item.req_type;
            cell_reg    <= cell_of(item.cell_index);
            src_reg     <= cell_of(item.source_index);
            coef_reg[0] <= item.coef_x;
            coef_reg[1] <= item.coef_y;
            coef_reg[2] <= item.coef_z;
            area_reg    <= item.face_size;
            val_reg[0]  <= item.val_density;
            val_reg[1]  <= item.val_vel_x;
            val_reg[2]  <= item.val_vel_y;
            val_reg[3]  <= item.val_vel_z;
            val_reg[4]  <= item.val_pressure;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_NB;
            dim_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            dim_reg   <= dim_next;
        end
    end

    // Sequencer: every lane gets the same control word, so the five variables
    // move through the read, multiply-accumulate and write steps in lock step.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        dim_next   = dim_reg;
        ctrl       = '0;
        ctrl.phase = phase_reg;
        ctrl.dim   = dim_reg;
        div_start  = 1'b0;
        emit_start = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (item.req_type == REQ_BEGIN) ? S_BEGIN : S_READ;
                end
            end
            S_BEGIN:
            begin
                ctrl.wr_en       = 1'b1;
                ctrl.wr_zero     = 1'b1;
                ctrl.load_centre = 1'b1;
                state_next       = S_IDLE;
            end
            S_READ:
            begin
                ctrl.rd_en = 1'b1;
                div_start  = (req_reg == REQ_REFLECT) && !area_zero;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                ctrl.load_grad = 1'b1;
                ctrl.clear_acc = 1'b1;
                dim_next       = '0;
                case (req_reg)
                    REQ_NEIGHBOR:
                    begin
                        phase_next = PH_NB;
                        state_next = S_MUL;
                    end
                    REQ_REFLECT:
                    begin
                        phase_next = PH_DOT;
                        state_next = area_zero ? S_WRITE : S_DIV;
                    end
                    default:
                    begin
                        state_next = S_SHOW;
                    end
                endcase
            end
            S_DIV:
            begin
                if (&div_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                ctrl.mul_en = 1'b1;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                ctrl.acc_en = 1'b1;
                if (dim_reg == 2'(NUM_DIMS - 1))
                begin
                    dim_next = '0;
                    if (phase_reg == PH_DOT)
                    begin
                        phase_next = PH_REF;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
                else
                begin
                    dim_next   = dim_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_WRITE:
            begin
                ctrl.wr_en = 1'b1;
                state_next = (req_reg == REQ_REFLECT) ? S_SHOW : S_IDLE;
            end
            S_SHOW:
            begin
                emit_start = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (emit_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // One divider per axis turns the raw face normal into a unit-area normal.
    for (genvar d = 0; d < NUM_DIMS; d++)
    begin : g_div
        lsgr_div u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .start (div_start),
            .num   (coef_reg[d]),
            .den   (area_reg),
            .quo   (nrm[d]),
            .done  (div_done[d])
        );
    end

    // One lane per flow variable, each with its own slice of the gradient store.
    for (genvar v = 0; v < NUM_VARS; v++)
    begin : g_lane
        lsgr_lane #(
            .MAX_CELLS (MAX_CELLS)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .rd_addr (rd_addr),
            .wr_addr (cell_reg),
            .val     (val_reg[v]),
            .coef    (coef_reg),
            .nrm     (nrm),
            .grad    (grads[v])
        );
    end

    lsgr_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (emit_start),
        .grads  (grads),
        .result (result),
        .done   (emit_done)
    );

    // No new request is taken while result beats are pending.
    `LSGR_ASSERT_SAME(a_idle_no_result, item.ready, !result.valid, "ready while results pending")
    // Taking the fifth beat returns the block to idle.
    `LSGR_ASSERT_NEXT(a_last_frees, result.valid && result.ready && result.last_result,
        item.ready, "block not idle after final beat")
    // An accepted request always leaves the block busy in the following cycle.
    `LSGR_ASSERT_NEXT(a_accept_busy, item.valid && item.ready, !item.ready,
        "ready right after accept")
    // The last flag marks exactly the pressure beat.
    `LSGR_ASSERT_SAME(a_last_code, result.valid,
        result.last_result == (result.var_index == VARW'(NUM_VARS - 1)), "last flag mismatch")
endmodule
`default_nettype wire
